// ----- design/vram_access_port_assert.svh -----
// assertion macros for the video ram access port checker
`ifndef VRAM_ACCESS_PORT_ASSERT_SVH
`define VRAM_ACCESS_PORT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define VAP_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define VAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/vap_pkg.sv -----
// ----------------------------------------------------------------------------
// vap_pkg
// Shared types and constants of the video ram access port.
// ----------------------------------------------------------------------------
`default_nettype none

package vap_pkg;

    // bus access kinds
    localparam logic [2:0] KIND_ADDR_LO = 3'd0;
    localparam logic [2:0] KIND_ADDR_HI = 3'd1;
    localparam logic [2:0] KIND_DATA_LO = 3'd2;
    localparam logic [2:0] KIND_DATA_HI = 3'd3;
    localparam logic [2:0] KIND_READ_LO = 3'd4;
    localparam logic [2:0] KIND_READ_HI = 3'd5;

    // register indexes
    localparam logic [1:0] REG_STEP    = 2'd0;
    localparam logic [1:0] REG_REMAP   = 2'd1;
    localparam logic [1:0] REG_ADVANCE = 2'd2;

    // remap modes
    localparam logic [1:0] REMAP_NONE = 2'd0;
    localparam logic [1:0] REMAP_8    = 2'd1;
    localparam logic [1:0] REMAP_9    = 2'd2;
    localparam logic [1:0] REMAP_10   = 2'd3;

    // step select codes
    localparam logic [1:0] STEP_1   = 2'd0;
    localparam logic [1:0] STEP_32  = 2'd1;

    localparam int ADDR_W = 16;
    localparam int WORD_W = 16;

    typedef enum logic [6:0] {
        ST_CLEAR = 7'b0000001,
        ST_IDLE  = 7'b0000010,
        ST_MUL   = 7'b0000100,
        ST_RED   = 7'b0001000,
        ST_RD    = 7'b0010000,
        ST_UPD   = 7'b0100000,
        ST_HOLD  = 7'b1000000
    } state_t;

    typedef struct packed {
        logic [1:0] step_select;
        logic [1:0] remap_mode;
        logic       advance_on_high;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic clr_en;
        logic mul_en;
        logic red_en;
        logic rd_en;
        logic upd_en;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
    } status_t;

    function automatic logic [ADDR_W-1:0] step_size(input logic [1:0] sel);
        logic [ADDR_W-1:0] s;
        unique case (sel)
            STEP_1:  s = 16'd1;
            STEP_32: s = 16'd32;
            default: s = 16'd128;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- design/vram_access_port.sv -----
// Video ram access port. After reset the block runs a clearing pass,
// writing zero to every word, and holds in_stall high meanwhile (register
// writes are taken as usual). Each accepted word then passes the states
// MUL, RED, RD and UPD (and HOLD while the result register is stalled)
// before the block can accept again: the remapped address is reduced
// modulo MEMORY_WORDS by a reciprocal multiply and a subtract-and-correct,
// then the single memory read port is read and the word is
// read-modified-written. One result word comes out for every input word;
// while it waits on out_stall the next input word is already accepted.
// ----------------------------------------------------------------------------
// vram_access_port
// CPU-side byte access port into a 16-bit-word video memory.
// ----------------------------------------------------------------------------
`default_nettype none

module vram_access_port #(
    parameter int unsigned MEMORY_WORDS = 32768
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // item channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  kind,
    input  wire logic [7:0]  write_byte,
    input  wire logic        access_blocked,
    // result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic      [7:0]  read_byte,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    logic [1:0]       step_select_reg;
    logic [1:0]       remap_mode_reg;
    logic             advance_on_high_reg;
    logic             reg_wr;
    vap_pkg::cfg_t    cfg;
    vap_pkg::cmd_t    cmd;
    vap_pkg::status_t status;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_select_reg     <= '0;
            remap_mode_reg      <= '0;
            advance_on_high_reg <= 1'b0;
        end
        else if (reg_wr)
        begin
            unique case (paddr[3:2])
                vap_pkg::REG_STEP:    step_select_reg     <= pwdata[1:0];
                vap_pkg::REG_REMAP:   remap_mode_reg      <= pwdata[1:0];
                vap_pkg::REG_ADVANCE: advance_on_high_reg <= pwdata[0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            vap_pkg::REG_STEP:    prdata = {30'd0, step_select_reg};
            vap_pkg::REG_REMAP:   prdata = {30'd0, remap_mode_reg};
            vap_pkg::REG_ADVANCE: prdata = {31'd0, advance_on_high_reg};
            default:              prdata = '0;
        endcase
    end

    assign cfg.step_select     = step_select_reg;
    assign cfg.remap_mode      = remap_mode_reg;
    assign cfg.advance_on_high = advance_on_high_reg;

    vap_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .status    (status)
    );

    vap_datapath #(
        .MEMORY_WORDS (MEMORY_WORDS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .kind           (kind),
        .write_byte     (write_byte),
        .access_blocked (access_blocked),
        .read_byte      (read_byte)
    );

endmodule

`default_nettype wire

// ----- design/vap_ram.sv -----
// ----------------------------------------------------------------------------
// vap_ram
// Generic single-write, single-read ram with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module vap_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ----- design/vap_ctrl.sv -----
// ----------------------------------------------------------------------------
// vap_ctrl
// Sequencer of the access port: clearing pass, per-word steps, output hold.
// ----------------------------------------------------------------------------
`default_nettype none

module vap_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_stall,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output vap_pkg::cmd_t         cmd,
    input  wire vap_pkg::status_t status
);

    vap_pkg::state_t state_reg, state_next;
    logic            out_valid_reg, out_valid_next;
    logic            accept;
    logic            out_load;

    assign in_stall = (state_reg != vap_pkg::ST_IDLE);
    assign accept   = in_valid && !in_stall;

    // result register is free or is being taken this cycle
    assign out_load = ((state_reg == vap_pkg::ST_UPD) || (state_reg == vap_pkg::ST_HOLD))
                      && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            vap_pkg::ST_CLEAR: if (status.clr_last) state_next = vap_pkg::ST_IDLE;
            vap_pkg::ST_IDLE:  if (accept) state_next = vap_pkg::ST_MUL;
            vap_pkg::ST_MUL:   state_next = vap_pkg::ST_RED;
            vap_pkg::ST_RED:   state_next = vap_pkg::ST_RD;
            vap_pkg::ST_RD:    state_next = vap_pkg::ST_UPD;
            vap_pkg::ST_UPD:   state_next = out_load ? vap_pkg::ST_IDLE : vap_pkg::ST_HOLD;
            vap_pkg::ST_HOLD:  if (out_load) state_next = vap_pkg::ST_IDLE;
            default:           state_next = vap_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        priority if (out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vap_pkg::ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cmd.accept   = accept;
    assign cmd.clr_en   = (state_reg == vap_pkg::ST_CLEAR);
    assign cmd.mul_en   = (state_reg == vap_pkg::ST_MUL);
    assign cmd.red_en   = (state_reg == vap_pkg::ST_RED);
    assign cmd.rd_en    = (state_reg == vap_pkg::ST_RD);
    assign cmd.upd_en   = (state_reg == vap_pkg::ST_UPD);
    assign cmd.out_load = out_load;

endmodule

`default_nettype wire

// ----- design/vap_datapath.sv -----
// ----------------------------------------------------------------------------
// vap_datapath
// Address, prefetch latch, address remap and reduction, memory access.
// ----------------------------------------------------------------------------
`default_nettype none

module vap_datapath #(
    parameter int unsigned MEMORY_WORDS = 32768
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire vap_pkg::cmd_t    cmd,
    output vap_pkg::status_t      status,
    input  wire vap_pkg::cfg_t    cfg,
    input  wire logic [2:0]       kind,
    input  wire logic [7:0]       write_byte,
    input  wire logic             access_blocked,
    output logic      [7:0]       read_byte
);

    localparam int          AW         = $clog2(MEMORY_WORDS);
    localparam logic [63:0] RECIP_FULL = 64'h1_0000_0000 / 64'(MEMORY_WORDS);
    localparam int          RW         = $clog2(RECIP_FULL + 64'd1);
    localparam logic [RW-1:0] RECIP    = RECIP_FULL[RW-1:0];
    localparam int          PW         = vap_pkg::ADDR_W + RW;
    localparam logic [AW-1:0] LAST_IDX = AW'(MEMORY_WORDS - 1);

    logic [vap_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [vap_pkg::WORD_W-1:0] prefetch_reg, prefetch_next;
    logic [AW-1:0]              clr_cnt_reg;

    logic [2:0]                 kind_reg;
    logic [7:0]                 byte_reg;
    logic                       blocked_reg;
    logic [7:0]                 res_reg;
    logic [7:0]                 out_byte_reg;
    logic [vap_pkg::ADDR_W-1:0] m_reg;
    logic [PW-1:0]              prod_reg;
    logic [vap_pkg::ADDR_W-1:0] rraw_reg;
    logic [AW-1:0]              idx_reg;

    logic [vap_pkg::ADDR_W-1:0] mapped;
    logic [31:0]                qn;
    logic [AW-1:0]              idx_fix;
    logic [vap_pkg::WORD_W-1:0] rdata;
    logic [vap_pkg::WORD_W-1:0] fetch;
    logic [vap_pkg::WORD_W-1:0] merged;
    logic                       is_write;
    logic                       is_read;
    logic                       advance_hit;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [vap_pkg::WORD_W-1:0] ram_wdata;

    // rotate the low group of address bits left by three; REMAP_NONE passes the address through
    always_comb
    begin
        unique case (cfg.remap_mode)
            vap_pkg::REMAP_8:  mapped = {addr_reg[15:8],  addr_reg[4:0], addr_reg[7:5]};
            vap_pkg::REMAP_9:  mapped = {addr_reg[15:9],  addr_reg[5:0], addr_reg[8:6]};
            vap_pkg::REMAP_10: mapped = {addr_reg[15:10], addr_reg[6:0], addr_reg[9:7]};
            default:           mapped = addr_reg;
        endcase
    end

    // modulo by reciprocal: the quotient estimate is low by at most one
    assign qn      = 32'(prod_reg[PW-1:32]) * 32'(MEMORY_WORDS);
    assign idx_fix = (17'(rraw_reg) >= 17'(MEMORY_WORDS))
                     ? AW'(17'(rraw_reg) - 17'(MEMORY_WORDS))
                     : AW'(rraw_reg);

    assign is_write    = (kind_reg == vap_pkg::KIND_DATA_LO) || (kind_reg == vap_pkg::KIND_DATA_HI);
    assign is_read     = (kind_reg == vap_pkg::KIND_READ_LO) || (kind_reg == vap_pkg::KIND_READ_HI);
    assign advance_hit = (is_write || is_read) && (cfg.advance_on_high == kind_reg[0]);
    assign fetch       = blocked_reg ? '0 : rdata;
    assign merged      = (kind_reg == vap_pkg::KIND_DATA_LO) ? {rdata[15:8], byte_reg}
                                                             : {byte_reg, rdata[7:0]};

    assign ram_we    = cmd.clr_en || (cmd.upd_en && is_write && !blocked_reg);
    assign ram_waddr = cmd.clr_en ? clr_cnt_reg : idx_reg;
    assign ram_wdata = cmd.clr_en ? '0 : merged;

    vap_ram #(
        .WIDTH (vap_pkg::WORD_W),
        .DEPTH (MEMORY_WORDS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (cmd.rd_en),
        .raddr (idx_fix),
        .rdata (rdata)
    );

    always_comb
    begin
        addr_next     = addr_reg;
        prefetch_next = prefetch_reg;
        if (cmd.accept)
        begin
            if (kind == vap_pkg::KIND_ADDR_LO)
                addr_next = {addr_reg[15:8], write_byte};
            else if (kind == vap_pkg::KIND_ADDR_HI)
                addr_next = {write_byte, addr_reg[7:0]};
        end
        if (cmd.upd_en)
        begin
            if ((kind_reg == vap_pkg::KIND_ADDR_LO) || (kind_reg == vap_pkg::KIND_ADDR_HI))
                prefetch_next = fetch;
            if (is_read && advance_hit)
                prefetch_next = fetch;
            if (advance_hit)
                addr_next = addr_reg + vap_pkg::step_size(cfg.step_select);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg     <= '0;
            prefetch_reg <= '0;
            clr_cnt_reg  <= '0;
        end
        else
        begin
            addr_reg     <= addr_next;
            prefetch_reg <= prefetch_next;
            if (cmd.clr_en)
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg    <= kind;
            byte_reg    <= write_byte;
            blocked_reg <= access_blocked;
            // reads see the latch as it stood before this word
            if (kind == vap_pkg::KIND_READ_LO)
                res_reg <= prefetch_reg[7:0];
            else if (kind == vap_pkg::KIND_READ_HI)
                res_reg <= prefetch_reg[15:8];
            else
                res_reg <= '0;
        end
        if (cmd.mul_en)
        begin
            m_reg    <= mapped;
            prod_reg <= PW'(mapped) * PW'(RECIP);
        end
        if (cmd.red_en)
            rraw_reg <= m_reg - qn[vap_pkg::ADDR_W-1:0];
        if (cmd.rd_en)
            idx_reg <= idx_fix;
        if (cmd.out_load)
            out_byte_reg <= res_reg;
    end

    assign status.clr_last = (clr_cnt_reg == LAST_IDX);
    assign read_byte       = out_byte_reg;

endmodule

`default_nettype wire

// ----- design/vap_checker.sv -----
// ----------------------------------------------------------------------------
// vap_checker
// Port-level checks of the access port, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "vram_access_port_assert.svh"

module vap_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_stall,
    input wire logic        out_valid,
    input wire logic        out_stall,
    input wire logic [7:0]  read_byte
);

    logic       in_acc;
    logic       out_acc;
    logic [1:0] pend_reg, pend_next;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // words accepted but not yet delivered
    always_comb
    begin
        pend_next = pend_reg;
        if (in_acc && !out_acc)
            pend_next = pend_reg + 2'd1;
        else if (!in_acc && out_acc)
            pend_next = pend_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else
            pend_reg <= pend_next;
    end

    `VAP_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_acc, in_stall ##1 in_stall ##1 in_stall ##1 in_stall, "input taken again before the word finished")
    `VAP_ASSERT_IMP(a_no_invented_word, clk, rst_n, out_valid, pend_reg != 2'd0, "result word without an accepted input word")
    `VAP_ASSERT_IMP(a_pending_bound, clk, rst_n, 1'b1, pend_reg != 2'd3, "more than two words outstanding")
    `VAP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(read_byte), "stalled result word dropped or changed")

endmodule

bind vram_access_port vap_checker u_vap_checker (.*);

`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the video ram access port: drives bus accesses
// under random gaps and output stalls, mirrors address, latch and memory in a
// scoreboard, and compares every read_byte word in order.
// ----------------------------------------------------------------------------
module tb;

    localparam int unsigned MEMORY_WORDS    = 32768;
    localparam int          ITEMS_PER_PHASE = 125;
    localparam int          NUM_PHASES      = 6;

    // step codes beyond the package ones, both give 128
    localparam logic [1:0] STEP_128     = 2'd2;
    localparam logic [1:0] STEP_128_ALT = 2'd3;

    // kinds the block ignores
    localparam logic [2:0] KIND_SPARE_6 = 3'd6;
    localparam logic [2:0] KIND_SPARE_7 = 3'd7;

    class vram_mirror;
        logic [1:0]  step_select;
        logic [1:0]  remap_mode;
        logic        advance_on_high;
        logic [15:0] word_address;
        logic [15:0] prefetch_word;
        logic [15:0] video_mem [MEMORY_WORDS];
        logic [7:0]  read_bytes_due [$];
        int          errors;

        function new();
            step_select     = '0;
            remap_mode      = '0;
            advance_on_high = 1'b0;
            word_address    = '0;
            prefetch_word   = '0;
            errors          = 0;
            foreach (video_mem[i])
                video_mem[i] = '0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                vap_pkg::REG_STEP:    step_select = val[1:0];
                vap_pkg::REG_REMAP:   remap_mode = val[1:0];
                vap_pkg::REG_ADVANCE: advance_on_high = val[0];
                default: ;
            endcase
        endfunction

        function int unsigned mem_index();
            logic [15:0] a;
            logic [15:0] m;
            a = word_address;
            case (remap_mode)
                vap_pkg::REMAP_8:  m = {a[15:8], a[4:0], a[7:5]};
                vap_pkg::REMAP_9:  m = {a[15:9], a[5:0], a[8:6]};
                vap_pkg::REMAP_10: m = {a[15:10], a[6:0], a[9:7]};
                default:           m = a;
            endcase
            return m % MEMORY_WORDS;
        endfunction

        function void refill_latch(logic blk);
            if (blk)
                prefetch_word = '0;
            else
                prefetch_word = video_mem[mem_index()];
        endfunction

        function void bump_address();
            case (step_select)
                vap_pkg::STEP_1:  word_address = word_address + 16'd1;
                vap_pkg::STEP_32: word_address = word_address + 16'd32;
                default:          word_address = word_address + 16'd128;
            endcase
        endfunction

        function void note_access(logic [2:0] k, logic [7:0] b, logic blk);
            logic [7:0]  rd;
            int unsigned idx;
            rd = '0;
            case (k)
                vap_pkg::KIND_ADDR_LO:
                begin
                    word_address[7:0] = b;
                    refill_latch(blk);
                end
                vap_pkg::KIND_ADDR_HI:
                begin
                    word_address[15:8] = b;
                    refill_latch(blk);
                end
                vap_pkg::KIND_DATA_LO, vap_pkg::KIND_DATA_HI:
                begin
                    if (!blk)
                    begin
                        idx = mem_index();
                        if (k == vap_pkg::KIND_DATA_LO)
                            video_mem[idx][7:0] = b;
                        else
                            video_mem[idx][15:8] = b;
                    end
                    if (advance_on_high == (k == vap_pkg::KIND_DATA_HI))
                        bump_address();
                end
                vap_pkg::KIND_READ_LO, vap_pkg::KIND_READ_HI:
                begin
                    // byte comes from the latch as it was before this access
                    rd = (k == vap_pkg::KIND_READ_LO) ? prefetch_word[7:0]
                                                      : prefetch_word[15:8];
                    if (advance_on_high == (k == vap_pkg::KIND_READ_HI))
                    begin
                        refill_latch(blk);
                        bump_address();
                    end
                end
                default: ;
            endcase
            read_bytes_due.push_back(rd);
        endfunction

        function void check_read_byte(logic [7:0] actual);
            logic [7:0] want;
            if (read_bytes_due.size() == 0)
            begin
                $display("%0t: read_byte %02h arrived with no word expected", $time, actual);
                errors++;
            end
            else
            begin
                want = read_bytes_due.pop_front();
                if (actual !== want)
                begin
                    $display("%0t: read_byte mismatch, expected %02h, actual %02h",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [2:0]  kind;
    logic [7:0]  write_byte;
    logic        access_blocked;
    logic        out_valid;
    logic        out_stall;
    logic [7:0]  read_byte;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    vram_mirror mirror;
    int         items_sent;
    bit         quiet;

    vram_access_port #(
        .MEMORY_WORDS(MEMORY_WORDS)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .kind           (kind),
        .write_byte     (write_byte),
        .access_blocked (access_blocked),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .read_byte      (read_byte),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    // result side: check accepted words, stall in random bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                mirror.check_read_byte(read_byte);
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (!quiet && rst_n && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    task automatic send_word(input logic [2:0] k, input logic [7:0] b, input logic blk);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid       <= 1'b1;
        kind           <= k;
        write_byte     <= b;
        access_blocked <= blk;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mirror.note_access(k, b, blk);
        if (k <= vap_pkg::KIND_READ_HI)
            items_sent++;
    endtask

    // setup, access, then back to idle on the bus
    task automatic write_reg(input logic [1:0] idx, input logic [1:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {30'd0, val};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror.set_reg(idx, {30'd0, val});
        @(posedge clk);
    endtask

    task automatic write_config(input logic [1:0] stp, input logic [1:0] rmp, input logic adv);
        write_reg(vap_pkg::REG_STEP, stp);
        write_reg(vap_pkg::REG_REMAP, rmp);
        write_reg(vap_pkg::REG_ADVANCE, {1'b0, adv});
    endtask

    // drain every expected word, then let the pipeline empty
    task automatic settle();
        in_valid <= 1'b0;
        while (mirror.read_bytes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    function automatic logic pick_blocked();
        return $urandom_range(0, 11) == 0;
    endfunction

    task automatic set_address(input logic [15:0] a);
        if ($urandom_range(0, 1))
        begin
            send_word(vap_pkg::KIND_ADDR_LO, a[7:0], pick_blocked());
            send_word(vap_pkg::KIND_ADDR_HI, a[15:8], pick_blocked());
        end
        else
        begin
            send_word(vap_pkg::KIND_ADDR_HI, a[15:8], pick_blocked());
            send_word(vap_pkg::KIND_ADDR_LO, a[7:0], pick_blocked());
        end
    endtask

    // two bytes of one word, the advancing byte last; sometimes just one
    task automatic word_pair(input logic [2:0] lo_k, input logic [2:0] hi_k);
        int sel;
        sel = $urandom_range(0, 7);
        if (sel == 0)
            send_word(lo_k, 8'($urandom), pick_blocked());
        else if (sel == 1)
            send_word(hi_k, 8'($urandom), pick_blocked());
        else if (mirror.advance_on_high)
        begin
            send_word(lo_k, 8'($urandom), pick_blocked());
            send_word(hi_k, 8'($urandom), pick_blocked());
        end
        else
        begin
            send_word(hi_k, 8'($urandom), pick_blocked());
            send_word(lo_k, 8'($urandom), pick_blocked());
        end
    endtask

    // set address, fill some words, go back and read them
    task automatic run_burst();
        logic [15:0] base;
        int          n;
        int          i;
        n = $urandom_range(0, 9);
        if (n < 6)
            base = 16'($urandom_range(0, 1023));
        else if (n < 8)
            base = 16'($urandom_range(16'h7f00, 16'h80ff));
        else
            base = 16'($urandom);
        n = $urandom_range(1, 6);
        set_address(base);
        for (i = 0; i < n; i++)
            word_pair(vap_pkg::KIND_DATA_LO, vap_pkg::KIND_DATA_HI);
        set_address(base);
        for (i = 0; i < n; i++)
            word_pair(vap_pkg::KIND_READ_LO, vap_pkg::KIND_READ_HI);
    endtask

    task automatic run_noise();
        int n;
        n = $urandom_range(1, 4);
        repeat (n)
            send_word(3'($urandom_range(0, 7)), 8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    task automatic run_directed();
        send_word(vap_pkg::KIND_ADDR_LO, 8'hff, 1'b0);
        send_word(vap_pkg::KIND_ADDR_HI, 8'hff, 1'b0);
        // top address, advance wraps to zero
        send_word(vap_pkg::KIND_DATA_LO, 8'ha5, 1'b0);
        send_word(vap_pkg::KIND_DATA_HI, 8'hff, 1'b0);
        send_word(vap_pkg::KIND_DATA_LO, 8'h00, 1'b0);
        // dropped write still advances
        send_word(vap_pkg::KIND_DATA_LO, 8'hff, 1'b1);
        send_word(vap_pkg::KIND_ADDR_LO, 8'h00, 1'b0);
        send_word(vap_pkg::KIND_ADDR_HI, 8'h00, 1'b0);
        send_word(vap_pkg::KIND_READ_HI, 8'h00, 1'b0);
        send_word(vap_pkg::KIND_READ_LO, 8'h00, 1'b0);
        send_word(vap_pkg::KIND_READ_LO, 8'hff, 1'b0);
        // blocked refill loads zero
        send_word(vap_pkg::KIND_ADDR_HI, 8'hff, 1'b1);
        send_word(vap_pkg::KIND_READ_LO, 8'h00, 1'b0);
        send_word(vap_pkg::KIND_READ_HI, 8'h00, 1'b0);
        send_word(vap_pkg::KIND_ADDR_LO, 8'hff, 1'b0);
        send_word(vap_pkg::KIND_READ_LO, 8'h00, 1'b1);
        send_word(vap_pkg::KIND_READ_LO, 8'h00, 1'b0);
        send_word(KIND_SPARE_6, 8'hff, 1'b1);
        send_word(KIND_SPARE_7, 8'h00, 1'b0);
        send_word(vap_pkg::KIND_READ_HI, 8'hff, 1'b0);
    endtask

    initial
    begin
        int ph;
        int target;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        kind           = vap_pkg::KIND_ADDR_LO;
        write_byte     = '0;
        access_blocked = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        items_sent     = 0;
        quiet          = 1'b0;
        mirror         = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: write_config(vap_pkg::STEP_1, vap_pkg::REMAP_NONE, 1'b0);
                1: write_config(STEP_128_ALT, vap_pkg::REMAP_10, 1'b1);
                2: write_config(vap_pkg::STEP_32, vap_pkg::REMAP_8, 1'b0);
                3: write_config(STEP_128, vap_pkg::REMAP_9, 1'b1);
                default: write_config(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                                      1'($urandom_range(0, 1)));
            endcase
            if (ph == NUM_PHASES - 1)
                quiet = 1'b1;
            if (ph == 0)
                run_directed();
            target = items_sent + ITEMS_PER_PHASE;
            while (items_sent < target)
            begin
                if ($urandom_range(0, 9) < 7)
                    run_burst();
                else
                    run_noise();
            end
            settle();
        end
        if (mirror.errors == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb failed");
        $finish;
    end

endmodule
